FILE: rtl/core/prtt_pkg.sv
`default_nettype none

package prtt_pkg;

  // Command codes on the input
  localparam logic [1:0] CMD_SEND = 2'd0;
  localparam logic [1:0] CMD_RESP = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_STORED    = 2'd0;
  localparam logic [1:0] KIND_MATCHED   = 2'd1;
  localparam logic [1:0] KIND_UNMATCHED = 2'd2;
  localparam logic [1:0] KIND_TIMEOUT   = 2'd3;

  localparam int unsigned IdW   = 29;
  localparam int unsigned CorrW = 16;
  localparam int unsigned TickW = 16;

  localparam logic [TickW-1:0] TimeoutReset = 16'd100;

  // One table entry as held in the memory
  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [CorrW-1:0] corr;
    logic [TickW-1:0] cnt;
  } entry_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic send;
    logic rd_shift;
    logic step_scan;
    logic wr_shift;
    logic fin_match;
    logic emit_unmatched;
    logic tick_upd;
    logic flush;
  } ctrl_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_done;
    logic hit;
    logic shift_done;
  } stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/prtt_ctrl.sv
`default_nettype none

module prtt_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  input  wire logic [1:0]      command_i,
  input  wire prtt_pkg::stat_t stat_i,
  output prtt_pkg::ctrl_t      ctrl_o,
  output logic                 busy
);
  import prtt_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_RSP_RD  = 3'd1;
  localparam logic [2:0] S_RSP_CMP = 3'd2;
  localparam logic [2:0] S_SHF_RD  = 3'd3;
  localparam logic [2:0] S_SHF_WR  = 3'd4;
  localparam logic [2:0] S_TCK_RD  = 3'd5;
  localparam logic [2:0] S_TCK_UPD = 3'd6;

  logic [2:0] state_q, state_d;

  // Sequence the scan, shift and tick walks
  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          ctrl_o.load = 1'b1;
          case (command_i)
            CMD_SEND: ctrl_o.send = 1'b1;
            CMD_RESP: state_d = S_RSP_RD;
            CMD_TICK: state_d = S_TCK_RD;
            default:  state_d = S_IDLE;
          endcase
        end
      end
      S_RSP_RD: begin
        if (stat_i.scan_done) begin
          ctrl_o.emit_unmatched = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_RSP_CMP;
        end
      end
      S_RSP_CMP: begin
        if (stat_i.hit) begin
          state_d = S_SHF_RD;
        end else begin
          ctrl_o.step_scan = 1'b1;
          state_d = S_RSP_RD;
        end
      end
      S_SHF_RD: begin
        if (stat_i.shift_done) begin
          ctrl_o.fin_match = 1'b1;
          state_d = S_IDLE;
        end else begin
          ctrl_o.rd_shift = 1'b1;
          state_d = S_SHF_WR;
        end
      end
      S_SHF_WR: begin
        ctrl_o.wr_shift = 1'b1;
        state_d = S_SHF_RD;
      end
      S_TCK_RD: begin
        if (stat_i.scan_done) begin
          ctrl_o.flush = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_TCK_UPD;
        end
      end
      S_TCK_UPD: begin
        ctrl_o.tick_upd  = 1'b1;
        ctrl_o.step_scan = 1'b1;
        state_d = S_TCK_RD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

`default_nettype wire

FILE: rtl/core/prtt_dp.sv
`default_nettype none

module prtt_dp #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire prtt_pkg::ctrl_t          ctrl_i,
  output prtt_pkg::stat_t               stat_o,
  input  wire logic [prtt_pkg::IdW-1:0]   can_id_i,
  input  wire logic [prtt_pkg::CorrW-1:0] correlation_id_i,
  input  wire logic                     cfg_we_i,
  input  wire logic [prtt_pkg::TickW-1:0] cfg_wdata_i,
  output logic                          event_valid_o,
  output logic [1:0]                    event_kind_o,
  output logic [prtt_pkg::IdW-1:0]      event_can_id_o,
  output logic [prtt_pkg::CorrW-1:0]    event_correlation_o,
  output logic                          evicted_oldest_o,
  output logic                          last_of_run_o
);
  import prtt_pkg::*;

  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [IW-1:0] LastSlot = IW'(TABLE_DEPTH - 1);
  localparam logic [CW-1:0] Full     = CW'(TABLE_DEPTH);

  function automatic logic [IW-1:0] slot_after(input logic [IW-1:0] s);
    return (s == LastSlot) ? '0 : s + IW'(1);
  endfunction

  entry_t                 mem_q [TABLE_DEPTH];
  entry_t                 rd_q, wdata;
  logic                   we;
  logic [IW-1:0]          waddr, raddr, last;
  logic [TABLE_DEPTH-1:0] armed_q, armed_d;
  logic [IW-1:0]          old_q, old_d, free_q, free_d, idx_q, idx_d;
  logic [CW-1:0]          cnt_q, cnt_d, n_q, n_d;
  logic [TickW-1:0]       tticks_q, tticks_d, init, dec;
  logic [IdW-1:0]         id_q, id_d, pend_id_q, pend_id_d, ev_id_q, ev_id_d;
  logic [CorrW-1:0]       corr_q, corr_d, pend_corr_q, pend_corr_d, ev_corr_q, ev_corr_d;
  logic                   pend_v_q, pend_v_d, ev_v_q, ev_v_d;
  logic [1:0]             ev_kind_q, ev_kind_d;
  logic                   ev_evict_q, ev_evict_d, ev_last_q, ev_last_d;

  assign last  = (free_q == '0) ? LastSlot : free_q - IW'(1);
  assign init  = (tticks_q == '0) ? TickW'(1) : tticks_q;
  assign dec   = rd_q.cnt - TickW'(1);
  assign raddr = ctrl_i.rd_shift ? slot_after(idx_q) : idx_q;

  assign stat_o.scan_done  = (n_q == cnt_q);
  assign stat_o.hit        = (rd_q.id == id_q) && (rd_q.corr == corr_q);
  assign stat_o.shift_done = (idx_q == last);

  // Work out table, pointer and result updates for each command
  always_comb begin
    armed_d     = armed_q;
    old_d       = old_q;
    free_d      = free_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    n_d         = n_q;
    tticks_d    = cfg_we_i ? cfg_wdata_i : tticks_q;
    id_d        = id_q;
    corr_d      = corr_q;
    pend_v_d    = pend_v_q;
    pend_id_d   = pend_id_q;
    pend_corr_d = pend_corr_q;
    ev_v_d      = 1'b0;
    ev_kind_d   = ev_kind_q;
    ev_id_d     = ev_id_q;
    ev_corr_d   = ev_corr_q;
    ev_evict_d  = 1'b0;
    ev_last_d   = 1'b1;
    we          = 1'b0;
    waddr       = idx_q;
    wdata       = rd_q;

    if (ctrl_i.load) begin
      id_d   = can_id_i;
      corr_d = correlation_id_i;
      idx_d  = old_q;
      n_d    = '0;
    end

    // Append, dropping the oldest when full
    if (ctrl_i.send) begin
      we             = 1'b1;
      waddr          = free_q;
      wdata.id       = can_id_i;
      wdata.corr     = correlation_id_i;
      wdata.cnt      = init;
      armed_d[free_q] = 1'b1;
      if (cnt_q == Full) begin
        old_d      = slot_after(old_q);
        ev_evict_d = 1'b1;
      end else begin
        cnt_d = cnt_q + CW'(1);
      end
      free_d    = slot_after(free_q);
      ev_v_d    = 1'b1;
      ev_kind_d = KIND_STORED;
      ev_id_d   = can_id_i;
      ev_corr_d = correlation_id_i;
    end

    if (ctrl_i.step_scan) begin
      idx_d = slot_after(idx_q);
      n_d   = n_q + CW'(1);
    end

    // Close the gap one slot per beat
    if (ctrl_i.wr_shift) begin
      we             = 1'b1;
      armed_d[idx_q] = armed_q[slot_after(idx_q)];
      idx_d          = slot_after(idx_q);
    end

    if (ctrl_i.fin_match) begin
      armed_d[last] = 1'b0;
      free_d        = last;
      cnt_d         = cnt_q - CW'(1);
      ev_v_d        = 1'b1;
      ev_kind_d     = KIND_MATCHED;
      ev_id_d       = id_q;
      ev_corr_d     = corr_q;
    end

    if (ctrl_i.emit_unmatched) begin
      ev_v_d    = 1'b1;
      ev_kind_d = KIND_UNMATCHED;
      ev_id_d   = id_q;
      ev_corr_d = corr_q;
    end

    // Count down; hold each expiry back one so the final one is marked
    if (ctrl_i.tick_upd && armed_q[idx_q]) begin
      we        = 1'b1;
      wdata.cnt = dec;
      if (dec == '0) begin
        armed_d[idx_q] = 1'b0;
        if (pend_v_q) begin
          ev_v_d    = 1'b1;
          ev_kind_d = KIND_TIMEOUT;
          ev_id_d   = pend_id_q;
          ev_corr_d = pend_corr_q;
          ev_last_d = 1'b0;
        end
        pend_v_d    = 1'b1;
        pend_id_d   = rd_q.id;
        pend_corr_d = rd_q.corr;
      end
    end

    if (ctrl_i.flush && pend_v_q) begin
      ev_v_d    = 1'b1;
      ev_kind_d = KIND_TIMEOUT;
      ev_id_d   = pend_id_q;
      ev_corr_d = pend_corr_q;
      pend_v_d  = 1'b0;
    end
  end

  // Entry memory
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rd_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q  <= '0;
      old_q    <= '0;
      free_q   <= '0;
      idx_q    <= '0;
      cnt_q    <= '0;
      n_q      <= '0;
      tticks_q <= TimeoutReset;
      pend_v_q <= 1'b0;
      ev_v_q   <= 1'b0;
    end else begin
      armed_q  <= armed_d;
      old_q    <= old_d;
      free_q   <= free_d;
      idx_q    <= idx_d;
      cnt_q    <= cnt_d;
      n_q      <= n_d;
      tticks_q <= tticks_d;
      pend_v_q <= pend_v_d;
      ev_v_q   <= ev_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q        <= id_d;
    corr_q      <= corr_d;
    pend_id_q   <= pend_id_d;
    pend_corr_q <= pend_corr_d;
    ev_kind_q   <= ev_kind_d;
    ev_id_q     <= ev_id_d;
    ev_corr_q   <= ev_corr_d;
    ev_evict_q  <= ev_evict_d;
    ev_last_q   <= ev_last_d;
  end

  assign event_valid_o       = ev_v_q;
  assign event_kind_o        = ev_kind_q;
  assign event_can_id_o      = ev_id_q;
  assign event_correlation_o = ev_corr_q;
  assign evicted_oldest_o    = ev_evict_q;
  assign last_of_run_o       = ev_last_q;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Full) else $error("pending count above depth");
  a_evict_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_v_q && ev_evict_q |-> ev_kind_q == KIND_STORED)
    else $error("eviction flag on a non-store result");
  a_full_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == Full |-> free_q == old_q) else $error("full table with split pointers");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/pending_request_timeout_tracker.sv
// Pending request tracker. Pulse start with a command while busy is low;
// results come out one at a time, each marked by event_valid_o for exactly
// one cycle, and cannot be held off. A response reads and compares each
// entry from the oldest on and, after a match, reads and writes each newer
// entry one slot down; a tick reads and updates each pending entry in turn.
// The entry memory has a registered read, one read port and one write port,
// and is walked one entry at a time. Results are registered and appear in
// the cycle after the beat that produces them; last_of_run_o marks the final
// one of a command.
`default_nettype none

module pending_request_timeout_tracker #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  command_i,
  input  wire logic [28:0] can_id_i,
  input  wire logic [15:0] correlation_id_i,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  output logic             event_valid_o,
  output logic [1:0]       event_kind_o,
  output logic [28:0]      event_can_id_o,
  output logic [15:0]      event_correlation_o,
  output logic             evicted_oldest_o,
  output logic             last_of_run_o
);
  import prtt_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  prtt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .command_i (command_i),
    .stat_i    (stat),
    .ctrl_o    (ctrl),
    .busy      (busy)
  );

  prtt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .ctrl_i              (ctrl),
    .stat_o              (stat),
    .can_id_i            (can_id_i),
    .correlation_id_i    (correlation_id_i),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .event_valid_o       (event_valid_o),
    .event_kind_o        (event_kind_o),
    .event_can_id_o      (event_can_id_o),
    .event_correlation_o (event_correlation_o),
    .evicted_oldest_o    (evicted_oldest_o),
    .last_of_run_o       (last_of_run_o)
  );

endmodule

`default_nettype wire
